// ===== design/bples_pkg.sv =====
// Shared constants, register indices and fixed-point helper functions of the energy sampler.
package bples_pkg;

	localparam int LF        = 24;           // fraction bits of base-2 logs
	localparam int LOG_STEPS = LF;           // squaring steps per log2
	localparam int EXP_STEPS = LF;           // root products per 2^x
	localparam int R_BITS    = 30;           // fraction bits of r
	localparam int DVD_BITS  = 46;           // dividend bits of the log/k divide
	localparam int DIV2_PER  = 4;            // quotient bits per divider stage
	localparam int DIV1_PER  = 3;
	localparam logic [30:0] Q30 = 31'h4000_0000;
	localparam logic [35:0] LOG_30 = 36'd503316480;   // 30.0 in log format

	typedef enum logic [2:0] {
		REG_ENERGY_MIN     = 3'd0,
		REG_ENERGY_MAX     = 3'd1,
		REG_ENERGY_BREAK   = 3'd2,
		REG_INDEX_LOW      = 3'd3,
		REG_INDEX_HIGH     = 3'd4,
		REG_SPLIT_FRACTION = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [4:0]  n;
		logic [31:0] m;
	} norm_t;

	typedef struct packed {
		logic [31:0] m;
		logic        b;
	} lstep_t;

	// leading-one position and mantissa with the top bit at 31; zero counts as one
	function automatic norm_t norm(input logic [31:0] v);
		norm_t       o;
		logic [31:0] w;
		w   = (v == 32'd0) ? 32'd1 : v;
		o.n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (w[i]) o.n = 5'(i);
		end
		o.m = w << (5'd31 - o.n);
		return o;
	endfunction

	// one bit of log2 by squaring the mantissa
	function automatic lstep_t log2_step(input logic [31:0] m);
		lstep_t      o;
		logic [63:0] sq;
		logic [32:0] t;
		sq = 64'(m) * 64'(m);
		t  = sq[63:31];
		if (t[32]) begin
			o.m = t[32:1];
			o.b = 1'b1;
		end else begin
			o.m = t[31:0];
			o.b = 1'b0;
		end
		return o;
	endfunction

	function automatic logic [31:0] isqrt(input logic [63:0] v);
		logic [31:0] res;
		logic [31:0] cand;
		logic [63:0] sq;
		res = 32'd0;
		for (int b = 31; b >= 0; b--) begin
			cand = res | (32'd1 << b);
			sq   = 64'(cand) * 64'(cand);
			if (sq <= v) res = cand;
		end
		return res;
	endfunction

	// 2^(2^-i) in Q30, from repeated truncating square roots
	function automatic logic [30:0] exp2_root(input int i);
		logic [63:0] root;
		root = 64'd2 << 30;
		for (int j = 1; j <= LF; j++) begin
			if (j <= i) root = 64'(isqrt(root << 30));
		end
		return root[30:0];
	endfunction

	function automatic logic [30:0] exp2_step(input logic [30:0] p, input logic [30:0] r);
		logic [63:0] pr;
		pr = 64'(p) * 64'(r);
		return pr[60:30];
	endfunction

endpackage

// ===== design/broken_power_law_energy_sampler_top.sv =====
// Top level of the broken power law energy sampler: config registers and full pipeline.
// One uniform sample in, one energy out, one item per cycle unless the output stalls. The
// pipeline holds 24-stage log2 squaring and 2^x root-product chains, a 10-stage fraction
// divider overlapped with the first log2 and a 12-stage divide of the log by (1 - index).
// The whole pipeline advances when the output register is empty or taken, so s_tready
// falls only while a result waits at the output. Registers must be written through the
// cfg channel (always ready) only while no item is in flight; the block does not enforce it.
module broken_power_law_energy_sampler_top #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // uniform_sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,  // energy
	output logic [1:0]                   m_tuser,  // upper_segment, saturated
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [((SAMPLE_BITS+1>32)?SAMPLE_BITS+1:32)-1:0] cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int LS     = bples_pkg::LOG_STEPS;
	localparam int ES     = bples_pkg::EXP_STEPS;
	localparam int D2N    = (bples_pkg::DVD_BITS + bples_pkg::DIV2_PER - 1) / bples_pkg::DIV2_PER;
	localparam int S_NORM = 2;
	localparam int S_L1   = S_NORM + 1;
	localparam int S_K    = S_L1 + LS;
	localparam int S_M    = S_K + 1;
	localparam int S_PP   = S_M + 1;
	localparam int S_E1   = S_PP + 1;
	localparam int S_Y    = S_E1 + ES;
	localparam int S_A    = S_Y + 1;
	localparam int S_NA   = S_A + 1;
	localparam int S_L2   = S_NA + 1;
	localparam int S_T    = S_L2 + LS;
	localparam int S_D    = S_T + 1;
	localparam int S_F    = S_D + D2N;
	localparam int S_E2   = S_F + 1;
	localparam int NS     = S_E2 + ES - 1;
	localparam logic [SB:0] ONE = (SB+1)'(1) << SB;

	typedef struct packed {
		logic        eq;
		logic [31:0] emin;
		logic        upper;
		logic [15:0] g;
		logic [SB:0] den;
		logic [SB:0] rem1;
		logic [29:0] r;
		logic [31:0] m_lo;
		logic [31:0] m_hi;
		logic [28:0] l_lo;
		logic [28:0] l_hi;
		logic        lneg;
		logic        kneg;
		logic        k0;
		logic        pos;
		logic [28:0] mag_l;
		logic [15:0] mag_k;
		logic [32:0] mm;
		logic [28:0] d;
		logic [8:0]  pn;
		logic        pf0;
		logic [23:0] x;
		logic [30:0] p;
		logic [30:0] y;
		logic [31:0] m_a;
		logic [28:0] l_a;
		logic        qneg;
		logic [15:0] rem2;
		logic [45:0] dvd;
		logic        sat;
		logic        under;
	} item_t;

	logic [31:0] energy_min_q, energy_max_q, energy_break_q;
	logic [15:0] index_low_q, index_high_q;
	logic [SB:0] split_q;

	logic          en;
	logic [NS:1]   vld;
	item_t         in1;
	item_t         st [1:NS];
	item_t         nx [2:NS];
	logic [SB-1:0] u;

	assign cfg_ready = 1'b1;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign u         = s_tdata[SB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_min_q   <= 32'd40960;
			energy_max_q   <= 32'd819200000;
			energy_break_q <= 32'd0;
			index_low_q    <= 16'd8192;
			index_high_q   <= 16'd8192;
			split_q        <= ONE;
		end else if (cfg_valid) begin
			unique case (bples_pkg::reg_idx_t'(cfg_index))
				bples_pkg::REG_ENERGY_MIN:     energy_min_q   <= cfg_data[31:0];
				bples_pkg::REG_ENERGY_MAX:     energy_max_q   <= cfg_data[31:0];
				bples_pkg::REG_ENERGY_BREAK:   energy_break_q <= cfg_data[31:0];
				bples_pkg::REG_INDEX_LOW:      index_low_q    <= cfg_data[15:0];
				bples_pkg::REG_INDEX_HIGH:     index_high_q   <= cfg_data[15:0];
				bples_pkg::REG_SPLIT_FRACTION: split_q        <= cfg_data[SB:0];
				default: ;
			endcase
		end
	end

	// segment select and divider operands
	always_comb begin
		logic [31:0] brk;
		logic [SB:0] a;
		logic        lt;
		in1 = '0;
		brk = (energy_break_q == 32'd0) ? energy_max_q : energy_break_q;
		a   = (energy_break_q == 32'd0 || split_q > ONE) ? ONE : split_q;
		lt  = {1'b0, u} < a;
		in1.eq    = energy_min_q == energy_max_q;
		in1.emin  = energy_min_q;
		in1.upper = !in1.eq && !lt;
		in1.g     = lt ? index_low_q : index_high_q;
		in1.m_lo  = lt ? energy_min_q : brk;
		in1.m_hi  = lt ? brk : energy_max_q;
		in1.rem1  = lt ? {1'b0, u} : {1'b0, u} - a;
		in1.den   = lt ? a : ONE - a;
	end

	function automatic item_t f_norm(input item_t s);
		item_t c;
		bples_pkg::norm_t nl, nh;
		c      = s;
		nl     = bples_pkg::norm(s.m_lo);
		nh     = bples_pkg::norm(s.m_hi);
		c.m_lo = nl.m;
		c.m_hi = nh.m;
		c.l_lo = 29'(nl.n);
		c.l_hi = 29'(nh.n);
		return c;
	endfunction

	function automatic item_t f_lstep(input item_t s, input int base);
		item_t c;
		bples_pkg::lstep_t a, b;
		logic [SB+1:0] t;
		logic          qb;
		c      = s;
		a      = bples_pkg::log2_step(s.m_lo);
		b      = bples_pkg::log2_step(s.m_hi);
		c.m_lo = a.m;
		c.m_hi = b.m;
		c.l_lo = {s.l_lo[27:0], a.b};
		c.l_hi = {s.l_hi[27:0], b.b};
		for (int j = 0; j < bples_pkg::DIV1_PER; j++) begin
			if (base + j < bples_pkg::R_BITS) begin
				t  = {c.rem1, 1'b0};
				qb = t >= {1'b0, c.den};
				if (qb) t = t - {1'b0, c.den};
				c.rem1 = t[SB:0];
				c.r    = {c.r[28:0], qb};
			end
		end
		return c;
	endfunction

	function automatic item_t f_k(input item_t s);
		item_t       c;
		logic [29:0] ld;
		logic [17:0] kk;
		logic        lnz;
		c       = s;
		ld      = {1'b0, s.l_hi} - {1'b0, s.l_lo};
		lnz     = ld != 30'd0;
		c.lneg  = ld[29];
		c.mag_l = ld[29] ? 29'(-ld) : ld[28:0];
		kk      = 18'd4096 - {{2{s.g[15]}}, s.g};
		c.kneg  = kk[17];
		c.k0    = kk == 18'd0;
		c.mag_k = kk[17] ? 16'(-kk) : kk[15:0];
		c.pos   = lnz && ((!c.kneg && !c.k0) == !c.lneg);
		return c;
	endfunction

	function automatic item_t f_m(input item_t s);
		item_t       c;
		logic [44:0] pm;
		logic [58:0] pd;
		c    = s;
		pm   = 45'(s.mag_k) * 45'(s.mag_l);
		pd   = 59'(s.r) * 59'(s.mag_l);
		c.mm = pm[44:12];
		c.d  = pd[58:30];
		return c;
	endfunction

	function automatic item_t f_pp(input item_t s);
		item_t       c;
		logic [24:0] xe;
		c     = s;
		c.pn  = s.mm[32:24];
		c.pf0 = s.mm[23:0] == 24'd0;
		xe    = 25'h100_0000 - {1'b0, s.mm[23:0]};
		c.x   = xe[23:0];
		c.p   = bples_pkg::Q30;
		return c;
	endfunction

	function automatic item_t f_estep(input item_t s, input int bidx, input logic [30:0] root);
		item_t c;
		c = s;
		if (s.x[bidx]) c.p = bples_pkg::exp2_step(s.p, root);
		return c;
	endfunction

	function automatic item_t f_y(input item_t s);
		item_t c;
		c = s;
		if (s.pn >= 9'd31)   c.y = 31'd0;
		else if (s.pf0)      c.y = bples_pkg::Q30 >> s.pn[4:0];
		else                 c.y = s.p >> (6'(s.pn[4:0]) + 6'd1);
		return c;
	endfunction

	function automatic item_t f_a(input item_t s);
		item_t       c;
		logic [30:0] rc, op, bs;
		logic [61:0] pr;
		c   = s;
		rc  = bples_pkg::Q30 - {1'b0, s.r};
		op  = s.pos ? rc : {1'b0, s.r};
		bs  = s.pos ? {1'b0, s.r} : rc;
		pr  = 62'(op) * 62'(s.y);
		c.m_a = {1'b0, bs} + pr[61:30];
		return c;
	endfunction

	function automatic item_t f_na(input item_t s);
		item_t c;
		bples_pkg::norm_t na;
		c     = s;
		na    = bples_pkg::norm(s.m_a);
		c.m_a = na.m;
		c.l_a = 29'(na.n);
		return c;
	endfunction

	function automatic item_t f_l2(input item_t s);
		item_t c;
		bples_pkg::lstep_t a;
		c     = s;
		a     = bples_pkg::log2_step(s.m_a);
		c.m_a = a.m;
		c.l_a = {s.l_a[27:0], a.b};
		return c;
	endfunction

	function automatic item_t f_t(input item_t s);
		item_t       c;
		logic [35:0] lt;
		logic [33:0] mt;
		c = s;
		if (s.pos) lt = 36'(s.mm) + 36'(s.l_a) - bples_pkg::LOG_30;
		else       lt = 36'(s.l_a) - bples_pkg::LOG_30;
		mt     = lt[35] ? 34'(-lt) : lt[33:0];
		c.qneg = lt[35] != s.kneg;
		c.dvd  = {mt, 12'd0};
		c.rem2 = 16'd0;
		return c;
	endfunction

	function automatic item_t f_dstep(input item_t s, input int base);
		item_t       c;
		logic [16:0] t;
		logic        qb;
		c = s;
		for (int j = 0; j < bples_pkg::DIV2_PER; j++) begin
			if (base + j < bples_pkg::DVD_BITS) begin
				t  = {c.rem2, c.dvd[45]};
				qb = t >= {1'b0, c.mag_k};
				if (qb) t = t - {1'b0, c.mag_k};
				c.rem2 = t[15:0];
				c.dvd  = {c.dvd[44:0], qb};
			end
		end
		return c;
	endfunction

	function automatic item_t f_f(input item_t s);
		item_t       c;
		logic [45:0] dm;
		logic        dn;
		logic [48:0] sd, fin;
		c  = s;
		dm = s.k0 ? 46'(s.d) : s.dvd;
		dn = s.k0 ? s.lneg : s.qneg;
		sd = dn ? 49'(-{3'b0, dm}) : {3'b0, dm};
		fin     = 49'(s.l_lo) + sd;
		c.under = fin[48];
		c.sat   = !fin[48] && (fin[47:29] != 19'd0);
		c.x     = fin[23:0];
		c.pn    = 9'(fin[28:24]);
		c.p     = bples_pkg::Q30;
		return c;
	endfunction

	for (genvar i = 2; i <= NS; i++) begin : g_stage
		if (i == S_NORM) begin : g_norm
			assign nx[i] = f_norm(st[i-1]);
		end else if (i >= S_L1 && i < S_K) begin : g_log
			assign nx[i] = f_lstep(st[i-1], (i - S_L1) * bples_pkg::DIV1_PER);
		end else if (i == S_K) begin : g_k
			assign nx[i] = f_k(st[i-1]);
		end else if (i == S_M) begin : g_m
			assign nx[i] = f_m(st[i-1]);
		end else if (i == S_PP) begin : g_pp
			assign nx[i] = f_pp(st[i-1]);
		end else if (i >= S_E1 && i < S_Y) begin : g_exp1
			localparam logic [30:0] ROOT = bples_pkg::exp2_root(i - S_E1 + 1);
			assign nx[i] = f_estep(st[i-1], bples_pkg::LF - 1 - (i - S_E1), ROOT);
		end else if (i == S_Y) begin : g_y
			assign nx[i] = f_y(st[i-1]);
		end else if (i == S_A) begin : g_a
			assign nx[i] = f_a(st[i-1]);
		end else if (i == S_NA) begin : g_na
			assign nx[i] = f_na(st[i-1]);
		end else if (i >= S_L2 && i < S_T) begin : g_log2
			assign nx[i] = f_l2(st[i-1]);
		end else if (i == S_T) begin : g_t
			assign nx[i] = f_t(st[i-1]);
		end else if (i >= S_D && i < S_F) begin : g_div
			assign nx[i] = f_dstep(st[i-1], (i - S_D) * bples_pkg::DIV2_PER);
		end else if (i == S_F) begin : g_f
			assign nx[i] = f_f(st[i-1]);
		end else begin : g_exp2
			localparam logic [30:0] ROOT = bples_pkg::exp2_root(i - S_E2 + 1);
			assign nx[i] = f_estep(st[i-1], bples_pkg::LF - 1 - (i - S_E2), ROOT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld      <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld      <= {vld[NS-1:1], s_tvalid};
			m_tvalid <= vld[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[1] <= in1;
			for (int i = 2; i <= NS; i++) st[i] <= nx[i];
		end
	end

	// result formatting
	always_ff @(posedge clk) begin
		if (en) begin
			if (st[NS].eq) begin
				m_tdata <= st[NS].emin;
				m_tuser <= 2'b00;
			end else if (st[NS].sat) begin
				m_tdata <= 32'hFFFF_FFFF;
				m_tuser <= {1'b1, st[NS].upper};
			end else if (st[NS].under) begin
				m_tdata <= 32'd0;
				m_tuser <= {1'b0, st[NS].upper};
			end else begin
				m_tdata <= {st[NS].p, 1'b0} >> (5'd31 - st[NS].pn[4:0]);
				m_tuser <= {1'b0, st[NS].upper};
			end
		end
	end

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 32'hFFFF_FFFF)
		else $error("saturated item without full-scale energy");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked output");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld))
		else $error("pipeline valids moved during stall");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the broken power law energy sampler top level.
`timescale 1ns / 1ps

module tb;

	localparam int  LOGF     = 24;
	localparam int  ONE      = 1 << 24;
	localparam int  LATENCY  = 118;
	localparam int  LIMIT    = 600000;

	typedef struct {
		logic [31:0] energy;
		logic        upper;
		logic        sat;
	} energy_t;

	class energy_scoreboard;
		logic [31:0] e_min, e_max, e_brk;
		logic [15:0] g_low, g_high;
		logic [24:0] split;
		energy_t     pending[$];
		int          errors;
		int          accepted;
		int          checked;

		function new();
			e_min  = 32'd40960;
			e_max  = 32'd819200000;
			e_brk  = 32'd0;
			g_low  = 16'd8192;
			g_high = 16'd8192;
			split  = 25'd16777216;
		endfunction

		function void set_reg(bples_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
			bples_pkg::REG_ENERGY_MIN: e_min = v;
			bples_pkg::REG_ENERGY_MAX: e_max = v;
			bples_pkg::REG_ENERGY_BREAK: e_brk = v;
			bples_pkg::REG_INDEX_LOW: g_low = v[15:0];
			bples_pkg::REG_INDEX_HIGH: g_high = v[15:0];
			bples_pkg::REG_SPLIT_FRACTION: split = v[24:0];
			default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		// 2^(x/2^24), 30 fraction bits
		function longint unsigned pow2_frac(longint unsigned x);
			longint unsigned root, p;
			root = 64'd2 << 30;
			p = 64'd1 << 30;
			for (int i = 1; i <= LOGF; i++) begin
				root = int_sqrt(root << 30);
				if ((x >> (LOGF - i)) & 1) p = (p * root) >> 30;
			end
			return p;
		endfunction

		function longint unsigned log2_fix(longint unsigned v);
			longint unsigned m, res;
			int n;
			if (v == 0) v = 1;
			n = 63;
			while (((v >> n) & 1) == 0) n--;
			m = (n >= 31) ? (v >> (n - 31)) : (v << (31 - n));
			res = longint'(n) << LOGF;
			for (int i = LOGF - 1; i >= 0; i--) begin
				m = (m * m) >> 31;
				if (m >= (64'd1 << 32)) begin
					m >>= 1;
					res |= 64'd1 << i;
				end
			end
			return res;
		endfunction

		function longint unsigned pow2_neg(longint unsigned m);
			longint unsigned n, f;
			n = m >> LOGF;
			f = m & ((64'd1 << LOGF) - 1);
			if (n >= 31) return 0;
			if (f == 0) return (64'd1 << 30) >> n;
			return pow2_frac((64'd1 << LOGF) - f) >> (n + 1);
		endfunction

		function longint unsigned absv(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		function logic [31:0] segment_energy(longint unsigned r, logic [31:0] lo,
				logic [31:0] hi, logic [15:0] gbits, output logic sat);
			longint llo, span, g, k, delta, fin, logt;
			longint unsigned m, y, arg, q, d, n, p, q30;
			bit pos;
			sat  = 1'b0;
			q30  = 64'd1 << 30;
			llo  = longint'(log2_fix(lo));
			span = longint'(log2_fix(hi)) - llo;
			g    = longint'($signed(gbits));
			k    = 4096 - g;
			if (k == 0) begin
				d = (r * absv(span)) >> 30;
				delta = (span < 0) ? -longint'(d) : longint'(d);
			end else begin
				m   = (absv(k) * absv(span)) >> 12;
				y   = pow2_neg(m);
				pos = (span != 0) && ((k > 0) == (span > 0));
				if (pos) begin
					arg  = r + (((q30 - r) * y) >> 30);
					logt = longint'(m) + longint'(log2_fix(arg)) - (longint'(30) << LOGF);
				end else begin
					arg  = (q30 - r) + ((r * y) >> 30);
					logt = longint'(log2_fix(arg)) - (longint'(30) << LOGF);
				end
				q = (absv(logt) << 12) / absv(k);
				delta = ((logt < 0) != (k < 0)) ? -longint'(q) : longint'(q);
			end
			fin = llo + delta;
			if (fin >= (longint'(32) << LOGF)) begin
				sat = 1'b1;
				return 32'hFFFF_FFFF;
			end
			if (fin < 0) return 32'd0;
			n = longint'(fin) >> LOGF;
			p = pow2_frac(longint'(fin) & ((64'd1 << LOGF) - 1));
			return (n >= 30) ? 32'(p << (n - 30)) : 32'(p >> (30 - n));
		endfunction

		function void note_sample(logic [23:0] u_in);
			energy_t x;
			longint unsigned u, a;
			logic [31:0] brk;
			u = u_in;
			a = split;
			brk = e_brk;
			x.upper = 1'b0;
			x.sat = 1'b0;
			if (e_min == e_max) begin
				x.energy = e_min;
			end else begin
				if (brk == 0) begin
					brk = e_max;
					a = ONE;
				end
				if (a > ONE) a = ONE;
				if (u < a) begin
					x.energy = segment_energy((u << 30) / a, e_min, brk, g_low, x.sat);
				end else begin
					x.upper = 1'b1;
					x.energy = segment_energy(((u - a) << 30) / (ONE - a), brk, e_max,
						g_high, x.sat);
				end
			end
			pending.insert(pending.size(), x);
			accepted++;
		endfunction

		function void check_energy(logic [31:0] e, logic up, logic st);
			energy_t x;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: energy %h", e);
				return;
			end
			x = pending.pop_front();
			if (e !== x.energy || up !== x.upper || st !== x.sat) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d: exp energy %h upper %b sat %b, got %h %b %b",
						checked, x.energy, x.upper, x.sat, e, up, st);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	energy_scoreboard sb;
	bit quiet;
	int cycles;
	int phases;

	broken_power_law_energy_sampler_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_sample(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_energy(m_tdata, m_tuser[0], m_tuser[1]);
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic write_reg(bples_pkg::reg_idx_t idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, v);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(logic [23:0] u);
		s_tvalid <= 1'b1;
		s_tdata  <= u;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		phases++;
	endtask

	task automatic set_all(logic [31:0] lo, logic [31:0] hi, logic [31:0] brk,
			logic [15:0] gl, logic [15:0] gh, logic [24:0] a);
		write_reg(bples_pkg::REG_ENERGY_MIN, lo);
		write_reg(bples_pkg::REG_ENERGY_MAX, hi);
		write_reg(bples_pkg::REG_ENERGY_BREAK, brk);
		write_reg(bples_pkg::REG_INDEX_LOW, {16'd0, gl});
		write_reg(bples_pkg::REG_INDEX_HIGH, {16'd0, gh});
		write_reg(bples_pkg::REG_SPLIT_FRACTION, {7'd0, a});
	endtask

	function automatic logic [31:0] rand_energy();
		case ($urandom_range(0, 5))
		0: return 32'($urandom_range(0, 4096));
		1: return $urandom;
		2: return 32'hFFFF_FFFF - $urandom_range(0, 100);
		default: return 32'($urandom_range(4096, 32'h3FFF_FFFF));
		endcase
	endfunction

	function automatic logic [15:0] rand_index();
		case ($urandom_range(0, 3))
		0: return 16'($urandom);
		1: return 16'd4096;
		default: return 16'($urandom_range(0, 16384));
		endcase
	endfunction

	function automatic logic [24:0] rand_split();
		case ($urandom_range(0, 5))
		0: return 25'($urandom_range(ONE, 25'h1FF_FFFF));
		1: return 25'd0;
		default: return 25'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic random_samples(int n);
		logic [23:0] u;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				u = 24'(sb.split + $urandom_range(0, 2) - 1);
			else
				u = 24'($urandom);
			send_sample(u);
		end
	endtask

	initial begin
		sb        = new();
		quiet     = 1'b0;
		cycles    = 0;
		phases    = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 24'd0;
		cfg_valid = 1'b0;
		cfg_index = bples_pkg::REG_ENERGY_MIN;
		cfg_data  = 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single segment, index 2
		send_sample(24'd0);
		send_sample(24'hFF_FFFF);
		send_sample(24'h80_0000);
		send_sample(24'd1);
		drain();

		// broken spectrum, log form below the break
		set_all(32'd40960, 32'd819200000, 32'd4096000, 16'd4096, 16'd10240, 25'h80_0000);
		send_sample(24'h7F_FFFF);
		send_sample(24'h80_0000);
		send_sample(24'h80_0001);
		send_sample(24'd0);
		send_sample(24'hFF_FFFF);
		drain();

		// saturation: steep negative index, wide range
		set_all(32'd1, 32'hFFFF_FFFF, 32'd0, 16'h8000, 16'h7FFF, 25'h1FF_FFFF);
		send_sample(24'hFF_FFFF);
		send_sample(24'h00_0000);
		send_sample(24'h55_5555);
		drain();

		// zero endpoint, reversed order, split zero
		set_all(32'd0, 32'd4096, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 25'd0);
		send_sample(24'd0);
		send_sample(24'hAA_AAAA);
		send_sample(24'hFF_FFFF);
		drain();

		// equal bounds
		set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12345, 16'd0, 16'd0, 25'd1);
		send_sample(24'h12_3456);
		send_sample(24'hFF_FFFF);
		drain();

		for (int p = 0; p < 9; p++) begin
			set_all(rand_energy(), rand_energy(),
				($urandom_range(0, 3) == 0) ? 32'd0 : rand_energy(),
				rand_index(), rand_index(), rand_split());
			if (p == 8) quiet = 1'b1;
			random_samples(60);
		drain();
		end

		repeat (LATENCY + 30) @(posedge clk);
		$display("%0d samples checked over %0d register settings, %0d errors",
			sb.checked, phases, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
